FILE: hdl/brla_pkg.sv
// ----------------------------------------------------------------------------
// brla_pkg: shared types and constants of the byte range lease allocator
// Holds the operation and error codes, the table geometry and the entry type.
// ----------------------------------------------------------------------------
package brla_pkg;

   localparam int LEASES = 16;
   localparam int IDX_W  = (LEASES > 1) ? $clog2(LEASES) : 1;
   localparam int CNT_W  = $clog2(LEASES + 1);

   localparam logic [47:0] DEFAULT_EXTENT = 48'd268435456;
   localparam logic [47:0] MAX48          = 48'hFFFF_FFFF_FFFF;

   localparam logic [1:0] OP_ASSIGN = 2'd0;
   localparam logic [1:0] OP_SENT   = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_RANGE = 2'd1;
   localparam logic [1:0] ERR_FULL     = 2'd2;
   localparam logic [1:0] ERR_NO_PEER  = 2'd3;

   localparam logic CSR_FILE_BYTES = 1'b0;
   localparam logic CSR_EXTENT     = 1'b1;

   typedef struct packed {
      logic [15:0] peer;
      logic [47:0] start;
      logic [47:0] length;
      logic [47:0] deadline;
      logic [47:0] sent;
   } entry_type;

endpackage

FILE: hdl/byte_range_lease_allocator.sv
// ----------------------------------------------------------------------------
// byte_range_lease_allocator: timed lease table over byte ranges of a file
// Grants, expires and accounts leases with one shared compare unit that a
// small sequencer steps through the lease table.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Contents
//   req_*     in         req_valid / req_ready  op, peer, time, ttl, bytes sent
//   rsp_*     out        rsp_valid / rsp_ready  status, granted lease, counts
//   csr_*     in         csr_wr_en              file size, extent
//
// One transaction is handled at a time; req_ready is high only when idle.
// Expire runs the expiry pass over the live leases, note sent scans them
// for the peer, and assign runs the expiry pass, then the gap search, then
// the end search, sizing and the table write. The single table read port
// visits one lease per cycle.
// The response register holds its transaction until rsp_ready; the next
// request is taken in the cycle after the response is accepted.
// Reset is synchronous: it idles, zeroes lease count and file size, defaults extent.
//
module byte_range_lease_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [15:0]           req_peer_id,
   input  logic [47:0]           req_now_ms,
   input  logic [31:0]           req_ttl_ms,
   input  logic [31:0]           req_sent_bytes,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output logic [1:0]            rsp_error_code,
   output logic [47:0]           rsp_lease_offset,
   output logic [47:0]           rsp_lease_length,
   output logic [47:0]           rsp_lease_expiry,
   output logic [47:0]           rsp_sent_total,
   output logic [4:0]            rsp_active_count,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [47:0]           csr_wdata
);
   import brla_pkg::*;

   // One-hot sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_EXP   = 9'b000000010,
      ST_CAND  = 9'b000000100,
      ST_COV   = 9'b000001000,
      ST_END   = 9'b000010000,
      ST_LEN   = 9'b000100000,
      ST_ALLOC = 9'b001000000,
      ST_SENT  = 9'b010000000,
      ST_RESP  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [47:0] file_bytes_ff, extent_ff;

   // Lease table, compacted: entries below cnt_ff are live.
   entry_type tbl_ff [LEASES];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Latched request.
   logic [1:0]  op_ff, op_in;
   logic [15:0] peer_ff, peer_in;
   logic [47:0] now_ff, now_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [31:0] sbytes_ff, sbytes_in;

   // Sequencer counters and search registers.
   logic [CNT_W-1:0] r_ff, r_in, w_ff, w_in, j_ff, j_in, k_ff, k_in;
   logic        first_ff, first_in;
   logic        found_ff, found_in;
   logic [47:0] best_ff, best_in;
   logic [47:0] cand_ff, cand_in;
   logic [47:0] end_ff, end_in;
   logic [47:0] len_ff, len_in;

   // Response registers.
   logic        ok_ff, ok_in;
   logic [1:0]  err_ff, err_in;
   logic [47:0] off_ff, off_in, rlen_ff, rlen_in, exp_ff, exp_in, tot_ff, tot_in;
   logic [4:0]  act_ff, act_in;

   // Shared table read port and compare unit operands.
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd;
   logic [47:0]      rd_end;

   // Single table write port.
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_data;

   logic [48:0] sum49;
   logic [47:0] diff, ext;

   always_comb begin
      case (state_ff)
         ST_EXP:  rd_idx = r_ff[IDX_W-1:0];
         ST_CAND: rd_idx = k_ff[IDX_W-1:0];
         ST_END:  rd_idx = k_ff[IDX_W-1:0];
         default: rd_idx = j_ff[IDX_W-1:0];
      endcase
   end

   assign rd     = tbl_ff[rd_idx];
   assign rd_end = rd.start + rd.length;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      peer_in  = peer_ff;
      now_in   = now_ff;
      ttl_in   = ttl_ff;
      sbytes_in = sbytes_ff;
      r_in     = r_ff;
      w_in     = w_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      first_in = first_ff;
      found_in = found_ff;
      best_in  = best_ff;
      cand_in  = cand_ff;
      end_in   = end_ff;
      len_in   = len_ff;
      ok_in    = ok_ff;
      err_in   = err_ff;
      off_in   = off_ff;
      rlen_in  = rlen_ff;
      exp_in   = exp_ff;
      tot_in   = tot_ff;
      act_in   = act_ff;
      wr_en    = 1'b0;
      wr_idx   = rd_idx;
      wr_data  = rd;
      sum49    = '0;
      diff     = end_ff - best_ff;
      ext      = (extent_ff == 48'd0) ? DEFAULT_EXTENT : extent_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               peer_in   = req_peer_id;
               now_in    = req_now_ms;
               ttl_in    = req_ttl_ms;
               sbytes_in = req_sent_bytes;
               ok_in     = 1'b0;
               err_in    = ERR_NONE;
               off_in    = '0;
               rlen_in   = '0;
               exp_in    = '0;
               tot_in    = '0;
               act_in    = 5'(cnt_ff);
               r_in      = '0;
               w_in      = '0;
               j_in      = '0;
               case (req_op)
                  OP_ASSIGN, OP_EXPIRE: state_in = ST_EXP;
                  OP_SENT:              state_in = ST_SENT;
                  default:              state_in = ST_RESP;
               endcase
            end
         end

         // Compaction pass: keep leases whose deadline is still ahead.
         ST_EXP: begin
            if (r_ff < cnt_ff) begin
               if (rd.deadline > now_ff) begin
                  wr_en   = 1'b1;
                  wr_idx  = w_ff[IDX_W-1:0];
                  wr_data = rd;
                  w_in    = w_ff + 1'b1;
               end
               r_in = r_ff + 1'b1;
            end else begin
               cnt_in = w_ff;
               act_in = 5'(w_ff);
               if (op_ff == OP_EXPIRE) begin
                  ok_in    = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  first_in = 1'b1;
                  found_in = 1'b0;
                  k_in     = '0;
                  state_in = ST_CAND;
               end
            end
         end

         // Candidate gap starts: offset zero, then the end of each lease.
         ST_CAND: begin
            if (first_ff) begin
               first_in = 1'b0;
               if (file_bytes_ff != 48'd0) begin
                  cand_in  = '0;
                  j_in     = '0;
                  state_in = ST_COV;
               end
            end else if (k_ff < cnt_ff) begin
               k_in = k_ff + 1'b1;
               if (rd_end < file_bytes_ff && (!found_ff || rd_end < best_ff)) begin
                  cand_in  = rd_end;
                  j_in     = '0;
                  state_in = ST_COV;
               end
            end else if (!found_ff) begin
               err_in   = ERR_NO_RANGE;
               state_in = ST_RESP;
            end else begin
               k_in     = '0;
               end_in   = file_bytes_ff;
               state_in = ST_END;
            end
         end

         // Coverage test of the candidate against every live lease.
         ST_COV: begin
            if (j_ff < cnt_ff) begin
               if (rd.start <= cand_ff && cand_ff < rd_end) begin
                  state_in = ST_CAND;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               best_in  = cand_ff;
               found_in = 1'b1;
               state_in = ST_CAND;
            end
         end

         // Nearest lease start above the chosen offset bounds the grant.
         ST_END: begin
            if (k_ff < cnt_ff) begin
               if (rd.start > best_ff && rd.start < end_ff) begin
                  end_in = rd.start;
               end
               k_in = k_ff + 1'b1;
            end else begin
               state_in = ST_LEN;
            end
         end

         ST_LEN: begin
            len_in   = (diff < ext) ? diff : ext;
            state_in = ST_ALLOC;
         end

         ST_ALLOC: begin
            if (cnt_ff >= CNT_W'(LEASES)) begin
               err_in = ERR_FULL;
            end else begin
               sum49            = {1'b0, now_ff} + {17'd0, ttl_ff};
               wr_en            = 1'b1;
               wr_idx           = cnt_ff[IDX_W-1:0];
               wr_data.peer     = peer_ff;
               wr_data.start    = best_ff;
               wr_data.length   = len_ff;
               wr_data.deadline = sum49[48] ? MAX48 : sum49[47:0];
               wr_data.sent     = '0;
               cnt_in           = cnt_ff + 1'b1;
               act_in           = 5'(cnt_ff + 1'b1);
               ok_in            = 1'b1;
               off_in           = best_ff;
               rlen_in          = len_ff;
               exp_in           = sum49[48] ? MAX48 : sum49[47:0];
            end
            state_in = ST_RESP;
         end

         // First lease held by the peer collects the sent bytes.
         ST_SENT: begin
            if (j_ff < cnt_ff) begin
               if (rd.peer == peer_ff) begin
                  sum49        = {1'b0, rd.sent} + {17'd0, sbytes_ff};
                  wr_en        = 1'b1;
                  wr_data.sent = sum49[48] ? MAX48 : sum49[47:0];
                  tot_in       = sum49[48] ? MAX48 : sum49[47:0];
                  ok_in        = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               err_in   = ERR_NO_PEER;
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         file_bytes_ff <= '0;
         extent_ff     <= DEFAULT_EXTENT;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FILE_BYTES: file_bytes_ff <= csr_wdata;
               CSR_EXTENT:     extent_ff     <= csr_wdata;
               default:        ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      peer_ff   <= peer_in;
      now_ff    <= now_in;
      ttl_ff    <= ttl_in;
      sbytes_ff <= sbytes_in;
      r_ff      <= r_in;
      w_ff      <= w_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      first_ff  <= first_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      cand_ff   <= cand_in;
      end_ff    <= end_in;
      len_ff    <= len_in;
      ok_ff     <= ok_in;
      err_ff    <= err_in;
      off_ff    <= off_in;
      rlen_ff   <= rlen_in;
      exp_ff    <= exp_in;
      tot_ff    <= tot_in;
      act_ff    <= act_in;
      if (wr_en) begin
         tbl_ff[wr_idx] <= wr_data;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_ok           = ok_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_lease_offset = off_ff;
   assign rsp_lease_length = rlen_ff;
   assign rsp_lease_expiry = exp_ff;
   assign rsp_sent_total   = tot_ff;
   assign rsp_active_count = act_ff;

endmodule

FILE: hdl/brla_checker.sv
// ----------------------------------------------------------------------------
// brla_checker: port-level checks of the byte range lease allocator
// Watches the request and response channels and the result fields.
// ----------------------------------------------------------------------------
module brla_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [1:0]  rsp_error_code,
   input logic [47:0] rsp_lease_length,
   input logic [4:0]  rsp_active_count
);
   import brla_pkg::*;

   // A pending response holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code)
         && $stable(rsp_ok))
      else $error("response changed while stalled");

   // Only one transaction is in flight at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // Success carries no error code.
   a_ok_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_error_code == ERR_NONE)
      else $error("ok with error code");

   // A failed transaction grants nothing, and the count stays in range.
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_lease_length == 48'd0
         && rsp_active_count <= 5'(LEASES))
      else $error("failed response carries a lease");

endmodule

bind byte_range_lease_allocator brla_checker u_brla_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_ok           (rsp_ok),
   .rsp_error_code   (rsp_error_code),
   .rsp_lease_length (rsp_lease_length),
   .rsp_active_count (rsp_active_count)
);

FILE: bench/tb_byte_range_lease_allocator.sv
// ----------------------------------------------------------------------------
// tb_byte_range_lease_allocator: self-checking bench of the lease allocator
// Drives assign, note sent and expire requests over the valid/ready request
// channel, predicts every response with a scoreboard that keeps its own copy
// of the lease table, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_byte_range_lease_allocator;
   import brla_pkg::*;

   // The fourth selector value is not an operation; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   // -------------------------------------------------------------------------
   // Scoreboard: a private model of the lease table. note_request computes the
   // response that a request must produce and queues it; check_response pops
   // the oldest queued response and compares it with what the block returned.
   // -------------------------------------------------------------------------
   class lease_scoreboard;
      typedef struct {
         logic        ok;
         logic [1:0]  err;
         logic [47:0] offset;
         logic [47:0] length;
         logic [47:0] expiry;
         logic [47:0] total;
         logic [4:0]  count;
      } lease_response;

      entry_type     leases[LEASES];
      int            live;
      logic [47:0]   file_bytes;
      logic [47:0]   extent;
      int            failures;
      lease_response expected_q[$];

      function new();
         live       = 0;
         file_bytes = '0;
         extent     = DEFAULT_EXTENT;
         failures   = 0;
      endfunction

      function void write_register(logic idx, logic [47:0] value);
         if (idx == CSR_FILE_BYTES) file_bytes = value;
         else extent = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Keep live leases whose deadline lies after now, preserving order.
      function void drop_expired(logic [47:0] now);
         int kept;
         kept = 0;
         for (int r = 0; r < live; r++) begin
            if (leases[r].deadline > now) begin
               leases[kept] = leases[r];
               kept++;
            end
         end
         live = kept;
      endfunction

      function bit covered(logic [47:0] pos);
         for (int i = 0; i < live; i++)
            if (leases[i].start <= pos &&
                {1'b0, pos} < {1'b0, leases[i].start} + {1'b0, leases[i].length})
               return 1;
         return 0;
      endfunction

      // Lowest free offset below the file size and the length granted there.
      function bit find_free_range(output logic [47:0] offset, output logic [47:0] length);
         bit          found;
         logic [47:0] best, stop, cap, cand;
         found = 0;
         best  = '0;
         if (file_bytes > 0 && !covered('0)) found = 1;
         for (int i = 0; i < live; i++) begin
            cand = leases[i].start + leases[i].length;
            if (cand < file_bytes && !covered(cand) && (!found || cand < best)) begin
               best  = cand;
               found = 1;
            end
         end
         offset = '0;
         length = '0;
         if (!found) return 0;
         stop = file_bytes;
         for (int i = 0; i < live; i++)
            if (leases[i].start > best && leases[i].start < stop) stop = leases[i].start;
         cap    = (extent == 0) ? DEFAULT_EXTENT : extent;
         offset = best;
         length = (stop - best < cap) ? stop - best : cap;
         return 1;
      endfunction

      function void note_request(logic [1:0] op, logic [15:0] peer, logic [47:0] now,
                                 logic [31:0] ttl, logic [31:0] sent);
         lease_response rsp;
         logic [48:0]   sum;
         logic [47:0]   offset, length;
         rsp = '{ok: 0, err: ERR_NONE, offset: 0, length: 0, expiry: 0, total: 0, count: 0};
         case (op)
            OP_ASSIGN: begin
               drop_expired(now);
               if (!find_free_range(offset, length)) begin
                  rsp.err = ERR_NO_RANGE;
               end else if (live >= LEASES) begin
                  rsp.err = ERR_FULL;
               end else begin
                  sum = {1'b0, now} + {17'b0, ttl};
                  rsp.expiry = sum[48] ? MAX48 : sum[47:0];
                  rsp.offset = offset;
                  rsp.length = length;
                  rsp.ok     = 1;
                  leases[live] = '{peer: peer, start: offset, length: length,
                                   deadline: rsp.expiry, sent: '0};
                  live++;
               end
            end
            OP_SENT: begin
               rsp.err = ERR_NO_PEER;
               for (int i = 0; i < live; i++) begin
                  if (leases[i].peer == peer) begin
                     sum = {1'b0, leases[i].sent} + {17'b0, sent};
                     leases[i].sent = sum[48] ? MAX48 : sum[47:0];
                     rsp.total = leases[i].sent;
                     rsp.ok    = 1;
                     rsp.err   = ERR_NONE;
                     break;
                  end
               end
            end
            OP_EXPIRE: begin
               drop_expired(now);
               rsp.ok = 1;
            end
            default: ;
         endcase
         rsp.count = live[4:0];
         expected_q.insert(expected_q.size(), rsp);
      endfunction

      function void compare(string name, logic [47:0] want, logic [47:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic ok, logic [1:0] err, logic [47:0] offset,
                                   logic [47:0] length, logic [47:0] expiry,
                                   logic [47:0] total, logic [4:0] count);
         lease_response want;
         if (expected_q.size() == 0) begin
            $error("response transaction arrived with no request outstanding");
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare("ok", want.ok, ok);
         compare("error_code", want.err, err);
         compare("lease_offset", want.offset, offset);
         compare("lease_length", want.length, length);
         compare("lease_expiry", want.expiry, expiry);
         compare("sent_total", want.total, total);
         compare("active_count", want.count, count);
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_op;
   logic [15:0] req_peer_id;
   logic [47:0] req_now_ms;
   logic [31:0] req_ttl_ms, req_sent_bytes;
   logic        rsp_valid, rsp_ready, rsp_ok;
   logic [1:0]  rsp_error_code;
   logic [47:0] rsp_lease_offset, rsp_lease_length, rsp_lease_expiry, rsp_sent_total;
   logic [4:0]  rsp_active_count;
   logic        csr_wr_en, csr_index;
   logic [47:0] csr_wdata;

   lease_scoreboard lease_board;
   int          send_idle_pct, recv_idle_pct;
   bit          hold_request;
   int          cycle_count;
   logic [47:0] now_clk;
   logic [15:0] peer_pool[8];

   byte_range_lease_allocator dut (.*);

   // Free-running clock; period of ten time units.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A correct run finishes far inside this limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response side. rsp_ready changes only at the falling edge. When the
   // stimulus asks for back-pressure, ready stays low for a long stretch
   // while the sender keeps offering requests, so the block has to stall
   // its request channel with a finished response parked in its output.
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every response transaction is checked at the rising edge that accepts it.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         lease_board.check_response(rsp_ok, rsp_error_code, rsp_lease_offset,
                                    rsp_lease_length, rsp_lease_expiry,
                                    rsp_sent_total, rsp_active_count);

   // Offers one request transaction. Entered and left at a falling edge.
   // The scoreboard learns of the request at the edge where it is accepted.
   task automatic send(logic [1:0] op, logic [15:0] peer, logic [47:0] now,
                       logic [31:0] ttl, logic [31:0] sent);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_op         = op;
      req_peer_id    = peer;
      req_now_ms     = now;
      req_ttl_ms     = ttl;
      req_sent_bytes = sent;
      req_valid      = 1;
      do @(posedge clock); while (!req_ready);
      lease_board.note_request(op, peer, now, ttl, sent);
      @(negedge clock);
      req_valid = 0;
   endtask

   // Waits until every expected response has been returned.
   task automatic drain();
      while (lease_board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Configuration is written only while the block is idle.
   task automatic write_csr(logic idx, logic [47:0] value);
      drain();
      csr_index = idx;
      csr_wdata = value;
      csr_wr_en = 1;
      @(negedge clock);
      csr_wr_en = 0;
      lease_board.write_register(idx, value);
   endtask

   // One random request. Times mostly creep forward so that leases live
   // long enough for the table to fill; peers come mostly from a small pool
   // so that note sent usually finds its lease.
   task automatic random_request();
      int          pick;
      logic [1:0]  op;
      logic [15:0] peer;
      logic [31:0] ttl;
      pick = $urandom_range(99);
      op   = (pick < 45) ? OP_ASSIGN : (pick < 75) ? OP_SENT :
             (pick < 93) ? OP_EXPIRE : OP_UNUSED;
      peer = ($urandom_range(99) < 85) ? peer_pool[$urandom_range(7)] : 16'($urandom);
      ttl  = ($urandom_range(99) < 80) ? 32'($urandom_range(0, 400)) : 32'($urandom);
      if ($urandom_range(99) < 3) now_clk = {16'($urandom), 32'($urandom)};
      else now_clk = now_clk + 48'($urandom_range(0, 40));
      send(op, peer, now_clk, ttl, 32'($urandom));
   endtask

   // A random configuration, with the extremes of both registers weighted in.
   task automatic random_config();
      int          pick;
      logic [47:0] size, ext;
      pick = $urandom_range(9);
      size = (pick == 0) ? 48'd0 : (pick == 1) ? MAX48 :
             (pick == 2) ? {16'($urandom), 32'($urandom)} : 48'($urandom_range(1, 600));
      pick = $urandom_range(9);
      ext  = (pick == 0) ? 48'd0 : (pick == 1) ? MAX48 : (pick == 2) ? 48'd1 :
             (pick == 3) ? {16'($urandom), 32'($urandom)} : 48'($urandom_range(1, 120));
      // A huge file cut into small extents still reaches a full table.
      write_csr(CSR_FILE_BYTES, size);
      write_csr(CSR_EXTENT, ext);
      now_clk = ($urandom_range(9) == 0) ? MAX48 - 48'($urandom_range(0, 2000))
                                         : {16'($urandom), 32'($urandom)};
      for (int i = 0; i < 8; i++) peer_pool[i] = 16'($urandom);
   endtask

   initial begin
      lease_board    = new();
      reset          = 1;
      req_valid      = 0;
      req_op         = OP_ASSIGN;
      req_peer_id    = '0;
      req_now_ms     = '0;
      req_ttl_ms     = '0;
      req_sent_bytes = '0;
      csr_wr_en      = 0;
      csr_index      = CSR_FILE_BYTES;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_request   = 0;
      now_clk        = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part. The file is empty after reset, so an assign finds no
      // range; the unused selector and an unknown peer change nothing.
      send(OP_ASSIGN, 16'h0001, 48'd0, 32'd100, 32'd0);
      send(OP_UNUSED, 16'hFFFF, MAX48, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(OP_SENT, 16'h1234, 48'd5, 32'd0, 32'd77);

      // A zero extent acts as the default, so one lease covers the whole file
      // and a second assign finds it fully leased.
      write_csr(CSR_FILE_BYTES, 48'd1000);
      write_csr(CSR_EXTENT, 48'd0);
      send(OP_ASSIGN, 16'hA5A5, 48'd10, 32'd100, 32'd0);
      send(OP_ASSIGN, 16'h5A5A, 48'd20, 32'd100, 32'd0);
      send(OP_SENT, 16'hA5A5, 48'd30, 32'd0, 32'hFFFF_FFFF);
      send(OP_SENT, 16'hA5A5, 48'd30, 32'd0, 32'hFFFF_FFFF);
      send(OP_EXPIRE, 16'h0000, 48'd110, 32'd0, 32'd0);

      // Small extents: sixteen leases fill the table, the next one is refused
      // although free bytes remain.
      write_csr(CSR_EXTENT, 48'd10);
      for (int i = 0; i < 17; i++)
         send(OP_ASSIGN, 16'(i), 48'd200, 32'd50, 32'd0);
      // Note sent does not expire: this lease is past its deadline yet found.
      send(OP_SENT, 16'd3, 48'd900, 32'd0, 32'd5);
      // Saturated expiry on the largest file and extent.
      write_csr(CSR_FILE_BYTES, MAX48);
      write_csr(CSR_EXTENT, MAX48);
      send(OP_ASSIGN, 16'hFFFF, MAX48 - 48'd1, 32'hFFFF_FFFF, 32'd0);
      send(OP_EXPIRE, 16'h0000, MAX48, 32'd0, 32'd0);

      // Random part in three idling phases, each spread over several
      // configurations. Back-pressure is forced once in the last phase.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 45 : 0;
         recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 9 : 0;
         for (int cfg = 0; cfg < 5; cfg++) begin
            random_config();
            if (phase == 2 && cfg == 1) hold_request = 1;
            for (int n = 0; n < 53; n++) random_request();
         end
      end

      drain();
      repeat (400) @(negedge clock);
      if (lease_board.failures == 0 && lease_board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
